### hw/rtl/rfrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrd_pkg
// Shared types and constants for the frame record deframer: header layout,
// check values, result kinds, error codes and the queued result word.
// ----------------------------------------------------------------------------
package rfrd_pkg;

  // Header layout: a fixed 32-byte little-endian block.
  localparam int HDR_BYTES = 32;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

  // Word slots of the header, selected by byte offset divided by four.
  localparam logic [2:0] SLOT_MAGIC  = 3'd0;
  localparam logic [2:0] SLOT_WIDTH  = 3'd2;
  localparam logic [2:0] SLOT_HEIGHT = 3'd3;
  localparam logic [2:0] SLOT_FORMAT = 3'd4;
  localparam logic [2:0] SLOT_SIZE   = 3'd5;
  localparam logic [2:0] SLOT_SEQ_LO = 3'd6;
  localparam logic [2:0] SLOT_SEQ_HI = 3'd7;

  // Check values.
  localparam logic [31:0] MAGIC_VALUE    = 32'h4752_4642;
  localparam logic [31:0] FORMAT_BGRA8   = 32'd2;
  localparam logic [14:0] DEFAULT_MAX_DIM = 15'd7680;

  // Dimension and register widths.
  localparam int DIM_W = 15;
  localparam int SEQ_W = 64;

  // Result kinds, carried on tuser of the output.
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Header error codes.
  typedef enum logic [1:0] {
    ERR_MAGIC     = 2'd0,
    ERR_DIMENSION = 2'd1,
    ERR_FORMAT    = 2'd2,
    ERR_SIZE      = 2'd3
  } err_t;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_ERROR   = 3'b100
  } phase_t;

  // One result word as it travels from the front to the back.
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        pbyte;
    logic              last;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [SEQ_W-1:0]  seq;
    err_t              err;
  } result_t;

  // Handshake between the queue and its neighbors.
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

### hw/rtl/rfrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrd_front
// Accepts stream bytes, collects the header, runs the header checks on the
// last header byte and classifies every byte into a result word or a drop.
// ----------------------------------------------------------------------------
module rfrd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,
  input  logic [0:0]             s_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [14:0]            cfg_data,
  output rfrd_pkg::hs_t          push_hs,
  input  logic                   push_full,
  output rfrd_pkg::result_t      push_data
);
  import rfrd_pkg::*;

  // Control state.
  phase_t                phase, phase_next;
  logic [HDR_IDX_W-1:0]  idx, idx_next;
  logic [14:0]           max_dim;

  // Header words and payload countdown.
  logic [31:0]           magic_word;
  logic [31:0]           width_word;
  logic [31:0]           height_word;
  logic [31:0]           format_word;
  logic [31:0]           size_word;
  logic [SEQ_W-1:0]      seq_word;
  logic [31:0]           remaining, remaining_next;
  logic [2*DIM_W-1:0]    area;

  // Per-byte decode.
  logic                  restart;
  logic                  take;
  phase_t                phase_cur;
  logic [HDR_IDX_W-1:0]  idx_cur;
  logic [31:0]           expect_size;
  logic                  bad_magic, bad_dim, bad_format, bad_size;

  assign s_tready  = !push_full;
  assign cfg_ready = 1'b1;

  assign restart   = s_tuser[0];
  assign take      = s_tvalid && s_tready;
  assign phase_cur = restart ? PH_HEADER : phase;
  assign idx_cur   = restart ? '0 : idx;

  // Width times height is ready long before the last header byte arrives.
  always_ff @(posedge clk) begin
    area <= width_word[DIM_W-1:0] * height_word[DIM_W-1:0];
  end

  assign expect_size = {area, 2'b00};

  // Header checks, in priority order magic, dimension, format, size.
  assign bad_magic  = (magic_word != MAGIC_VALUE);
  assign bad_dim    = (width_word == '0) || (height_word == '0) ||
                      (width_word > {17'd0, max_dim}) ||
                      (height_word > {17'd0, max_dim});
  assign bad_format = (format_word != FORMAT_BGRA8);
  assign bad_size   = (size_word != expect_size);

  // Classification and next state.
  always_comb begin
    phase_next      = phase;
    idx_next        = idx;
    remaining_next  = remaining;
    push_hs.valid   = 1'b0;
    push_hs.ready   = !push_full;
    push_data       = '0;
    push_data.kind  = KIND_PAYLOAD;
    push_data.err   = ERR_MAGIC;
    if (take) begin
      case (phase_cur)
        PH_HEADER: begin
          phase_next = PH_HEADER;
          if (idx_cur != HDR_LAST) begin
            idx_next = idx_cur + 1'b1;
          end else begin
            idx_next      = '0;
            push_hs.valid = 1'b1;
            if (bad_magic || bad_dim || bad_format || bad_size) begin
              phase_next     = PH_ERROR;
              push_data.kind = KIND_ERROR;
              if (bad_magic) begin
                push_data.err = ERR_MAGIC;
              end else if (bad_dim) begin
                push_data.err = ERR_DIMENSION;
              end else if (bad_format) begin
                push_data.err = ERR_FORMAT;
              end else begin
                push_data.err = ERR_SIZE;
              end
            end else begin
              phase_next       = PH_PAYLOAD;
              remaining_next   = size_word;
              push_data.kind   = KIND_ACCEPT;
              push_data.width  = width_word[DIM_W-1:0];
              push_data.height = height_word[DIM_W-1:0];
              push_data.seq    = {s_tdata, seq_word[SEQ_W-9:0]};
            end
          end
        end
        PH_PAYLOAD: begin
          push_hs.valid   = 1'b1;
          push_data.kind  = KIND_PAYLOAD;
          push_data.pbyte = s_tdata;
          if (remaining <= 32'd1) begin
            push_data.last = 1'b1;
            remaining_next = '0;
            phase_next     = PH_HEADER;
            idx_next       = '0;
          end else begin
            remaining_next = remaining - 32'd1;
          end
        end
        default: begin
          // Error phase and unused codes drop the byte.
          phase_next = phase;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEADER;
      idx     <= '0;
      max_dim <= DEFAULT_MAX_DIM;
    end else begin
      phase <= phase_next;
      idx   <= idx_next;
      if (cfg_valid && cfg_ready) begin
        max_dim <= cfg_data;
      end
    end
  end

  // Header byte store, one byte lane per accepted header byte.
  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    if (take && phase_cur == PH_HEADER) begin
      case (idx_cur[4:2])
        SLOT_MAGIC:  magic_word[{idx_cur[1:0], 3'b000} +: 8]  <= s_tdata;
        SLOT_WIDTH:  width_word[{idx_cur[1:0], 3'b000} +: 8]  <= s_tdata;
        SLOT_HEIGHT: height_word[{idx_cur[1:0], 3'b000} +: 8] <= s_tdata;
        SLOT_FORMAT: format_word[{idx_cur[1:0], 3'b000} +: 8] <= s_tdata;
        SLOT_SIZE:   size_word[{idx_cur[1:0], 3'b000} +: 8]   <= s_tdata;
        SLOT_SEQ_LO, SLOT_SEQ_HI: seq_word[{idx_cur[2:0], 3'b000} +: 8] <= s_tdata;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/rfrd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrd_queue
// Two-entry result queue between the front and the back, so that each side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module rfrd_queue (
  input  logic                clk,
  input  logic                rst,
  input  rfrd_pkg::hs_t       push_hs,
  input  rfrd_pkg::result_t   push_data,
  output logic                full,
  output logic                pop_valid,
  input  logic                pop,
  output rfrd_pkg::result_t   pop_data
);
  import rfrd_pkg::*;

  result_t     mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push_hs.valid && push_hs.ready;
  assign do_pop    = pop && pop_valid;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/rfrd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrd_back
// Output stage: takes result words from the queue into the output register
// and packs them onto the master stream.
// ----------------------------------------------------------------------------
module rfrd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop,
  input  rfrd_pkg::result_t   pop_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [103:0]        m_tdata,
  output logic [1:0]          m_tuser,
  output logic                m_tlast
);
  import rfrd_pkg::*;

  result_t out_word;

  // Load whenever the register is empty or its word is being taken.
  assign pop = pop_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= pop_data;
    end
  end

  // Pack fields from the lowest bit up.
  assign m_tdata = {out_word.err, out_word.seq, out_word.height,
                    out_word.width, out_word.pbyte};
  assign m_tuser = out_word.kind;
  assign m_tlast = out_word.last;

endmodule

### hw/rtl/raw_frame_record_deframer.sv
`timescale 1ns / 1ps
// A result word is written into the queue at the edge that accepts its byte (the
// front is combinational) and moves into the output register once that register is
// empty or its word is being taken. Throughput: one byte per cycle, header and
// payload alike, while the result queue is not full; its two entries let the slave
// side keep taking bytes during an output stall until both are in use.
// Reset (synchronous, rst high): parser at header start, queue and output
// empty, max_dimension back to 7680.
// ----------------------------------------------------------------------------
// raw_frame_record_deframer
// Splits a byte stream of video frame records into header results and
// payload bytes, with header checks and drop-until-restart on error.
// ----------------------------------------------------------------------------
module raw_frame_record_deframer (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] data_byte
  input  logic [0:0]    s_tuser,   // [0] restart
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [14:0]   cfg_data,  // [14:0] max_dimension
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // [7:0] payload_byte, [22:8] frame_width,
                                   // [37:23] frame_height,
                                   // [101:38] frame_sequence, [103:102] error_code
  output logic [1:0]    m_tuser,   // [1:0] result_kind
  output logic          m_tlast    // last_of_frame
);
  import rfrd_pkg::*;

  hs_t      push_hs;
  result_t  push_data;
  logic     push_full;
  logic     pop_valid;
  logic     pop;
  result_t  pop_data;

  rfrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push_hs   (push_hs),
    .push_full (push_full),
    .push_data (push_data)
  );

  rfrd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_hs   (push_hs),
    .push_data (push_data),
    .full      (push_full),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  rfrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

### hw/rtl/rfrd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrd_checker
// Port-level checks on the deframer's output stream, bound to the top level.
// ----------------------------------------------------------------------------
module rfrd_checker (
  input logic          clk,
  input logic          rst,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [103:0]  m_tdata,
  input logic [1:0]    m_tuser,
  input logic          m_tlast
);
  import rfrd_pkg::*;

  // A stalled word stays on the bus unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output word changed while stalled");

  // The end-of-frame mark only comes with a payload byte.
  a_last_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == KIND_PAYLOAD)
    else $error("tlast on a header result");

  // An accepted header always reports nonzero dimensions.
  a_accept_dims: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ACCEPT |-> m_tdata[22:8] != '0 && m_tdata[37:23] != '0)
    else $error("accepted header with zero dimension");

  // An error result carries nothing but its code.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ERROR |-> m_tdata[101:0] == '0 && !m_tlast)
    else $error("error result carries data");

endmodule

bind raw_frame_record_deframer rfrd_checker u_rfrd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
